@@ sv/sha_pkg.sv @@
// Package: SHA-256 types, constants and round functions.
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef logic [7:0][31:0] chain_t;

    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [31:0] wdata;
    } ram_req_t;

    localparam chain_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ sv/sha_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
// Compression engine: 64 rounds with the message schedule kept in the word RAM.
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire chain_t      chain,
    input  wire logic [31:0] rdata,
    output ram_req_t         req,
    output logic             done,
    output chain_t           vars
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RD0  = 3'd1;
    localparam logic [2:0] C_RD1  = 3'd2;
    localparam logic [2:0] C_RD2  = 3'd3;
    localparam logic [2:0] C_RD3  = 3'd4;
    localparam logic [2:0] C_RD4  = 3'd5;
    localparam logic [2:0] C_WSUM = 3'd6;
    localparam logic [2:0] C_RND  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        done_reg, done_next;
    chain_t      v_reg, v_next;
    logic [31:0] w16_reg, s0_reg, x7_reg, s1_reg, w_reg;
    logic [31:0] t1, t2, ch, maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + bsig1(v_reg[4]) + ch + round_k(rnd_reg) + w_reg;
    assign t2  = bsig0(v_reg[0]) + maj;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        done_next  = 1'b0;
        v_next     = v_reg;
        req.we     = 1'b0;
        req.addr   = rnd_reg[3:0];
        req.wdata  = w16_reg + s0_reg + x7_reg + s1_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    v_next     = chain;
                    rnd_next   = '0;
                    state_next = C_RD0;
                end
            end
            C_RD0: state_next = C_RD1;
            C_RD1:
            begin
                req.addr   = rnd_reg[3:0] + 4'd1;
                state_next = rnd_reg[5:4] == 2'd0 ? C_RND : C_RD2;
            end
            C_RD2:
            begin
                req.addr   = rnd_reg[3:0] + 4'd9;
                state_next = C_RD3;
            end
            C_RD3:
            begin
                req.addr   = rnd_reg[3:0] + 4'd14;
                state_next = C_RD4;
            end
            C_RD4: state_next = C_WSUM;
            C_WSUM:
            begin
                req.we     = 1'b1;
                state_next = C_RND;
            end
            C_RND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    state_next = C_RD0;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (state_reg == C_RD1)
        begin
            w16_reg <= rdata;
            w_reg   <= rdata;
        end
        if (state_reg == C_RD2)
        begin
            s0_reg <= ssig0(rdata);
        end
        if (state_reg == C_RD3)
        begin
            x7_reg <= rdata;
        end
        if (state_reg == C_RD4)
        begin
            s1_reg <= ssig1(rdata);
        end
        if (state_reg == C_WSUM)
        begin
            w_reg <= req.wdata;
        end
    end

    assign done = done_reg;
    assign vars = v_reg;

endmodule
`default_nettype wire

@@ sv/sha256_stream_hash_top.sv @@
// Top level: byte packing, padding sequencer, chaining words and digest output.
//
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_ready
//  out     | out | out_item_t | out_valid / out_ready
//
// One byte per cycle while a block fills; the 64th byte of a block stalls input
// while the compression engine runs its rounds through the single RAM port.
// An end mark adds padding writes, one or two blocks, and eight output
// transfers. Reset restores the initial hash and a zero count.
// Output stalls hold the current word; no input is taken until the digest is out.
`default_nettype none
module sha256_stream_hash_top
    import sha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] POST_IDLE  = 2'd0;
    localparam logic [1:0] POST_PAD   = 2'd1;
    localparam logic [1:0] POST_FINAL = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  post_reg, post_next;
    logic [60:0] total_reg, total_next;
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  idx_reg, idx_next;
    logic        len_ok_reg, len_ok_next;
    logic [2:0]  oidx_reg, oidx_next;
    chain_t      chain_reg, chain_next;
    logic        core_start;
    ram_req_t    top_req, core_req, ram_req;
    logic [31:0] rdata;
    logic        core_done;
    chain_t      core_vars;
    logic        take;

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .chain (chain_reg),
        .rdata (rdata),
        .req   (core_req),
        .done  (core_done),
        .vars  (core_vars)
    );

    assign ram_req = (state_reg == ST_HASH) ? core_req : top_req;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rdata)
    );

    assign in_ready = state_reg == ST_IDLE;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        post_next     = post_reg;
        total_next    = total_reg;
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        len_ok_next   = len_ok_reg;
        oidx_next     = oidx_reg;
        chain_next    = chain_reg;
        core_start    = 1'b0;
        top_req.we    = 1'b0;
        top_req.addr  = total_reg[5:2];
        top_req.wdata = {acc_reg, in_data.msg_byte};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (in_data.byte_present)
                    begin
                        acc_next   = {acc_reg[15:0], in_data.msg_byte};
                        total_next = total_reg + 61'd1;
                        top_req.we = total_reg[1:0] == 2'd3;
                    end
                    if (in_data.byte_present && total_reg[5:0] == 6'd63)
                    begin
                        core_start = 1'b1;
                        post_next  = in_data.end_of_message ? POST_PAD : POST_IDLE;
                        state_next = ST_HASH;
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                top_req.we = 1'b1;
                case (total_reg[1:0])
                    2'd0:    top_req.wdata = {PAD_BYTE, 24'h0};
                    2'd1:    top_req.wdata = {acc_reg[7:0], PAD_BYTE, 16'h0};
                    2'd2:    top_req.wdata = {acc_reg[15:0], PAD_BYTE, 8'h0};
                    default: top_req.wdata = {acc_reg[23:0], PAD_BYTE};
                endcase
                idx_next    = {1'b0, total_reg[5:2]} + 5'd1;
                len_ok_next = total_reg[5:0] < 6'd56;
                post_next   = POST_FINAL;
                state_next  = ST_ZERO;
            end
            ST_ZERO:
            begin
                top_req.addr = idx_reg[3:0];
                if (len_ok_reg && idx_reg == 5'd14)
                begin
                    top_req.wdata = total_reg[60:29];
                end
                else if (len_ok_reg && idx_reg == 5'd15)
                begin
                    top_req.wdata = {total_reg[28:0], 3'b000};
                end
                else
                begin
                    top_req.wdata = '0;
                end
                if (idx_reg[4])
                begin
                    core_start = 1'b1;
                    state_next = ST_HASH;
                end
                else
                begin
                    top_req.we = 1'b1;
                    idx_next   = idx_reg + 5'd1;
                end
            end
            ST_HASH:
            begin
                if (core_done)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_next[i] = chain_reg[i] + core_vars[i];
                    end
                    unique case (post_reg)
                        POST_IDLE: state_next = ST_IDLE;
                        POST_PAD:  state_next = ST_PAD;
                        default:
                        begin
                            if (!len_ok_reg)
                            begin
                                len_ok_next = 1'b1;
                                idx_next    = '0;
                                state_next  = ST_ZERO;
                            end
                            else
                            begin
                                oidx_next  = '0;
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        chain_next = H_INIT;
                        total_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            post_reg   <= POST_IDLE;
            total_reg  <= '0;
            idx_reg    <= '0;
            len_ok_reg <= 1'b0;
            oidx_reg   <= '0;
            chain_reg  <= H_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            post_reg   <= post_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            len_ok_reg <= len_ok_next;
            oidx_reg   <= oidx_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign out_valid            = state_reg == ST_OUT;
    assign out_data.digest_word = chain_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = oidx_reg == 3'd7;

endmodule
`default_nettype wire

@@ sv/sha_chk.sv @@
// Port-level checker for the stream hash, bound to the top level.
`default_nettype none
module sha_chk
    import sha_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest pending");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("digest word order broken");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid && in_ready)
        else $error("no return to input after last word");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_word == (out_data.word_index == 3'd7))
        else $error("last_word mismatch");

endmodule

bind sha256_stream_hash_top sha_chk u_sha_chk (.*);
`default_nettype wire
